// ----- rtl/core/i2c_target_rx_packet_queue_core_assert.svh -----
// Assertion macros used by the checker file of the receive packet queue.
`ifndef I2C_TARGET_RX_PACKET_QUEUE_CORE_ASSERT_SVH
`define I2C_TARGET_RX_PACKET_QUEUE_CORE_ASSERT_SVH

// General clocked assertion, disabled while reset is asserted.
`define I2CRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled beat keeps its valid and its payload.
`define I2CRQ_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
    `I2CRQ_ASSERT(lbl, clk, rst_n, vld && !rdy |=> vld && $stable(sig), msg)

`endif

// ----- rtl/core/i2crq_pkg.sv -----
// Package with sizes, codes and shared types of the receive packet queue.
package i2crq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int FRAME_BYTES = 32;

    // One physical slot more than the ring holds, so the frame being assembled
    // always has a free slot of its own and never needs a copy on push.
    localparam int SLOTS     = QUEUE_DEPTH + 1;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int IDX_W     = $clog2(FRAME_BYTES);
    localparam int CNT_W     = $clog2(FRAME_BYTES + 1);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W    = SLOT_W + IDX_W;
    localparam int RAM_DEPTH = SLOTS * (1 << IDX_W);

    localparam int BYTE_W = 8;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 6;
    localparam int DROP_W = 8;
    localparam int LEFT_W = 4;

    typedef enum logic [2:0] {
        FUNC_START = 3'd0,
        FUNC_BYTE  = 3'd1,
        FUNC_STOP  = 3'd2,
        FUNC_ERROR = 3'd3,
        FUNC_POP   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        RD_IDLE,
        RD_FETCH,
        RD_LOAD,
        RD_EMPTY
    } rd_state_t;

    typedef struct packed {
        logic              start;
        logic              empty;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  len;
        logic [DROP_W-1:0] dropped;
        logic [QCNT_W-1:0] left;
    } pop_req_t;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

// ----- rtl/core/i2c_target_rx_packet_queue_core.sv -----
// Top level of the I2C target receive packet queue.
// Events arrive as beats on the slave side; the event code rides in s_tuser and the
// data byte in s_tdata. Start, byte, stop and bus-error beats are taken one per cycle
// while no pop is in progress; byte beats write straight into the free slot of a slot
// memory that has one slot more than the ring holds, so a push is only a pointer
// update. A pop beat streams the oldest packet out on the master side, one beat per
// byte with tlast on the final one, or a single beat with tuser low when the ring is
// empty. Each byte of a pop is read from the slot memory, whose read port is
// registered, and loaded into the output register before the next one is fetched;
// the slave side is not ready until the pop's final beat is loaded; an empty pop
// waits until the output register is free. No clearing pass is needed after reset.
module i2c_target_rx_packet_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [2:0]  s_tuser,   // [2:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [12:8] byte_position,
                                   // [18:13] packet_length, [26:19] overflow_count,
                                   // [30:27] packets_left, [31] zero
    output logic [0:0]  m_tuser,   // [0] packet_valid
    output logic        m_tlast
);

    logic                         accept;
    logic                         rd_idle;
    logic                         ram_we;
    logic [i2crq_pkg::ADDR_W-1:0] ram_waddr;
    logic [i2crq_pkg::BYTE_W-1:0] ram_wdata;
    logic                         ram_re;
    logic [i2crq_pkg::ADDR_W-1:0] ram_raddr;
    logic [i2crq_pkg::BYTE_W-1:0] ram_rdata;
    i2crq_pkg::pop_req_t          pop_req;

    assign s_tready = rd_idle;
    assign accept   = s_tvalid && s_tready;

    i2crq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (i2crq_pkg::func_t'(s_tuser)),
        .rx_byte   (s_tdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .pop_req   (pop_req)
    );

    i2crq_ram #(
        .DATA_W (i2crq_pkg::BYTE_W),
        .DEPTH  (i2crq_pkg::RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    i2crq_reader u_reader (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_req   (pop_req),
        .idle      (rd_idle),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- rtl/core/i2crq_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module i2crq_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 288,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/i2crq_ctrl.sv -----
// Frame assembly, ring pointers, slot lengths and the drop counter.
module i2crq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  i2crq_pkg::func_t              func,
    input  logic [i2crq_pkg::BYTE_W-1:0]  rx_byte,
    output logic                          ram_we,
    output logic [i2crq_pkg::ADDR_W-1:0]  ram_waddr,
    output logic [i2crq_pkg::BYTE_W-1:0]  ram_wdata,
    output i2crq_pkg::pop_req_t           pop_req
);

    logic [i2crq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                         receiving_reg, receiving_next;
    logic [i2crq_pkg::SLOT_W-1:0] rp_reg, rp_next;
    logic [i2crq_pkg::SLOT_W-1:0] wp_reg, wp_next;
    logic [i2crq_pkg::QCNT_W-1:0] queued_reg, queued_next;
    logic [i2crq_pkg::DROP_W-1:0] dropped_reg, dropped_next;
    logic [i2crq_pkg::CNT_W-1:0]  lengths_reg [i2crq_pkg::SLOTS];

    logic                         push_req;
    logic [i2crq_pkg::CNT_W-1:0]  push_len;
    logic                         len_we;

    always_comb
    begin
        count_next     = count_reg;
        receiving_next = receiving_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        queued_next    = queued_reg;
        dropped_next   = dropped_reg;
        ram_we         = 1'b0;
        ram_waddr      = {wp_reg, count_reg[i2crq_pkg::IDX_W-1:0]};
        ram_wdata      = rx_byte;
        push_req       = 1'b0;
        push_len       = count_reg;
        len_we         = 1'b0;
        pop_req        = '0;
        pop_req.dropped = dropped_reg;

        if (accept)
        begin
            case (func)
                i2crq_pkg::FUNC_START:
                begin
                    count_next     = '0;
                    receiving_next = 1'b1;
                end
                i2crq_pkg::FUNC_BYTE:
                begin
                    if (receiving_reg && count_reg < i2crq_pkg::CNT_W'(i2crq_pkg::FRAME_BYTES))
                    begin
                        ram_we = 1'b1;
                        if (count_reg == i2crq_pkg::CNT_W'(i2crq_pkg::FRAME_BYTES - 1))
                        begin
                            push_req       = 1'b1;
                            push_len       = i2crq_pkg::CNT_W'(i2crq_pkg::FRAME_BYTES);
                            count_next     = '0;
                            receiving_next = 1'b0;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                i2crq_pkg::FUNC_STOP:
                begin
                    push_req       = (count_reg != '0);
                    count_next     = '0;
                    receiving_next = 1'b0;
                end
                i2crq_pkg::FUNC_ERROR:
                begin
                    push_req       = (count_reg > i2crq_pkg::CNT_W'(1));
                    count_next     = '0;
                    receiving_next = 1'b0;
                end
                i2crq_pkg::FUNC_POP:
                begin
                    pop_req.start = 1'b1;
                    if (queued_reg == '0)
                    begin
                        pop_req.empty = 1'b1;
                    end
                    else
                    begin
                        pop_req.slot = rp_reg;
                        pop_req.len  = lengths_reg[rp_reg];
                        pop_req.left = queued_reg - 1'b1;
                        rp_next      = i2crq_pkg::slot_inc(rp_reg);
                        queued_next  = queued_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // A push and a pop never come from the same beat.
        if (push_req)
        begin
            if (queued_reg >= i2crq_pkg::QCNT_W'(i2crq_pkg::QUEUE_DEPTH))
            begin
                dropped_next = dropped_reg + 1'b1;
            end
            else
            begin
                len_we      = 1'b1;
                wp_next     = i2crq_pkg::slot_inc(wp_reg);
                queued_next = queued_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            receiving_reg <= 1'b0;
            rp_reg        <= '0;
            wp_reg        <= '0;
            queued_reg    <= '0;
            dropped_reg   <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            receiving_reg <= receiving_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            queued_reg    <= queued_next;
            dropped_reg   <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            lengths_reg[wp_reg] <= push_len;
        end
    end

endmodule

// ----- rtl/core/i2crq_reader.sv -----
// Pop sequencer: reads a packet slot byte by byte into the output register, or an empty beat.
module i2crq_reader (
    input  logic                          clk,
    input  logic                          rst_n,
    input  i2crq_pkg::pop_req_t           pop_req,
    output logic                          idle,
    output logic                          ram_re,
    output logic [i2crq_pkg::ADDR_W-1:0]  ram_raddr,
    input  logic [i2crq_pkg::BYTE_W-1:0]  ram_rdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast
);

    i2crq_pkg::rd_state_t state_reg, state_next;

    logic [i2crq_pkg::SLOT_W-1:0] slot_reg;
    logic [i2crq_pkg::CNT_W-1:0]  len_reg;
    logic [i2crq_pkg::IDX_W-1:0]  idx_reg;
    logic [i2crq_pkg::DROP_W-1:0] dropped_reg;
    logic [i2crq_pkg::QCNT_W-1:0] left_reg;

    logic                         out_valid_reg;
    logic                         out_pv_reg;
    logic [i2crq_pkg::BYTE_W-1:0] out_byte_reg;
    logic [i2crq_pkg::POS_W-1:0]  out_pos_reg;
    logic [i2crq_pkg::LEN_W-1:0]  out_len_reg;
    logic                         out_last_reg;
    logic [i2crq_pkg::DROP_W-1:0] out_drop_reg;
    logic [i2crq_pkg::LEFT_W-1:0] out_left_reg;

    logic out_free;
    logic is_last;
    logic load_pkt;
    logic load_empty;

    assign out_free = !out_valid_reg || m_tready;
    assign is_last  = ((i2crq_pkg::CNT_W'(idx_reg) + 1'b1) == len_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            i2crq_pkg::RD_IDLE:
            begin
                if (pop_req.start)
                begin
                    state_next = pop_req.empty ? i2crq_pkg::RD_EMPTY : i2crq_pkg::RD_FETCH;
                end
            end
            i2crq_pkg::RD_FETCH:
            begin
                state_next = i2crq_pkg::RD_LOAD;
            end
            i2crq_pkg::RD_LOAD:
            begin
                if (out_free)
                begin
                    state_next = is_last ? i2crq_pkg::RD_IDLE : i2crq_pkg::RD_FETCH;
                end
            end
            i2crq_pkg::RD_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = i2crq_pkg::RD_IDLE;
                end
            end
            default:
            begin
                state_next = i2crq_pkg::RD_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idle       = (state_reg == i2crq_pkg::RD_IDLE);
        ram_re     = (state_reg == i2crq_pkg::RD_FETCH);
        ram_raddr  = {slot_reg, idx_reg};
        load_pkt   = (state_reg == i2crq_pkg::RD_LOAD) && out_free;
        load_empty = (state_reg == i2crq_pkg::RD_EMPTY) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2crq_pkg::RD_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_pkt || load_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop_req.start)
            begin
                idx_reg <= '0;
            end
            else if (load_pkt)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_req.start)
        begin
            slot_reg    <= pop_req.slot;
            len_reg     <= pop_req.len;
            dropped_reg <= pop_req.dropped;
            left_reg    <= pop_req.left;
        end
        if (load_pkt)
        begin
            out_pv_reg   <= 1'b1;
            out_byte_reg <= ram_rdata;
            out_pos_reg  <= i2crq_pkg::POS_W'(idx_reg);
            out_len_reg  <= i2crq_pkg::LEN_W'(len_reg);
            out_last_reg <= is_last;
            out_drop_reg <= dropped_reg;
            out_left_reg <= i2crq_pkg::LEFT_W'(left_reg);
        end
        else if (load_empty)
        begin
            out_pv_reg   <= 1'b0;
            out_byte_reg <= '0;
            out_pos_reg  <= '0;
            out_len_reg  <= '0;
            out_last_reg <= 1'b1;
            out_drop_reg <= dropped_reg;
            out_left_reg <= '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_left_reg, out_drop_reg, out_len_reg, out_pos_reg, out_byte_reg};
    assign m_tuser  = out_pv_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/core/i2crq_checker.sv -----
// Port-level checker for the receive packet queue, bound to the top level.
`include "i2c_target_rx_packet_queue_core_assert.svh"

module i2crq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    `I2CRQ_ASSERT_HOLD(a_out_hold, clk, rst_n, m_tvalid, m_tready, m_tdata, "stalled beat changed")

    `I2CRQ_ASSERT(a_empty_form, clk, rst_n, m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[18:0] == 19'd0), "empty pop beat malformed")

    `I2CRQ_ASSERT(a_last_mark, clk, rst_n, m_tvalid && m_tuser[0] |-> (m_tlast == (({1'b0, m_tdata[12:8]} + 6'd1) == m_tdata[18:13])), "tlast disagrees with byte position")

    `I2CRQ_ASSERT(a_left_bound, clk, rst_n, m_tvalid |-> (m_tdata[30:27] <= 4'(i2crq_pkg::QUEUE_DEPTH)), "packets left beyond ring depth")

    `I2CRQ_ASSERT(a_pop_busy, clk, rst_n, s_tvalid && s_tready && (s_tuser == i2crq_pkg::FUNC_POP) |=> !s_tready, "pop did not hold off the slave side")

endmodule

bind i2c_target_rx_packet_queue_core i2crq_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
